### hw/rtl/subset_sum_unneeded_item_count_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the subset-sum unneeded-count core
// Clocked, reset-qualified property checks; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef SUBSET_SUM_UNNEEDED_ITEM_COUNT_CORE_MACROS_SVH
`define SUBSET_SUM_UNNEEDED_ITEM_COUNT_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check an implication on every rising clk edge outside reset.
`define SSUC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ssuc assertion failed");
// Check a plain condition on every rising clk edge outside reset.
`define SSUC_ALWAYS(lbl, cond) \
  `SSUC_ASSERT(lbl, 1'b1 |-> (cond))
`else
`define SSUC_ASSERT(lbl, prop)
`define SSUC_ALWAYS(lbl, cond)
`endif
`endif

### hw/rtl/ssuc_pkg.sv
// ---------------------------------------------------------------------------
// ssuc_pkg
// Widths and default sizes for the subset-sum unneeded-count core.
// ---------------------------------------------------------------------------
package ssuc_pkg;
  localparam int MAX_ITEMS_DEF  = 4096;
  localparam int MAX_TARGET_DEF = 4096;
  localparam int VALUE_W        = 20;
  localparam int TARGET_W       = 13;
  localparam int COUNT_W        = 13;
  localparam int IN_TDATA_W     = 24;
  localparam int OUT_TDATA_W    = 16;
endpackage

### hw/rtl/subset_sum_unneeded_item_count_core.sv
// ---------------------------------------------------------------------------
// subset_sum_unneeded_item_count_core
// Sorted value store plus a bit-serial subset-sum sweep and binary search.
// ---------------------------------------------------------------------------
// Values stream in one per transaction and are insertion-sorted into a
// store with one read port and one write port; an insertion reads and
// compares entries from the top down (S_INS_RD, S_INS_CMP), shifting each
// larger one up one place, then writes the new value (S_INS_PUT). The
// transaction with tlast set starts the computation: the largest value is
// checked, then the smallest, then the index is bisected, about log2(n)+2
// checks. Each check of a nonzero value a below the effective target K
// clears a K-bit reachability memory but for bit 0, folds every other
// nonzero value v below K into it with one shared OR step per bit for K-v
// bits, and scans the window [K-a, K-1]. The input is not ready during that
// work. The result (unneeded_count) waits in an output register; loading of
// the next set may start meanwhile, and its computation starts once the
// earlier result has been taken. No clearing pass follows reset.
// ---------------------------------------------------------------------------
`include "subset_sum_unneeded_item_count_core_macros.svh"

module subset_sum_unneeded_item_count_core #(
  parameter int MAX_ITEMS  = ssuc_pkg::MAX_ITEMS_DEF,
  parameter int MAX_TARGET = ssuc_pkg::MAX_TARGET_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write: target_sum
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ssuc_pkg::TARGET_W-1:0]      cfg_data,
  // input stream; tdata: item_value[19:0], zero fill [23:20]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ssuc_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tlast,   // last_item
  // result stream; tdata: unneeded_count[12:0], zero fill [15:13]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ssuc_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int TW   = $clog2(MAX_TARGET + 1);  // value / target width
  localparam int RW   = $clog2(MAX_TARGET);      // reach address width
  localparam int IW   = $clog2(MAX_ITEMS + 1);   // item count width
  localparam int XW   = $clog2(MAX_ITEMS);       // store index width
  localparam int CW   = ssuc_pkg::COUNT_W;

  typedef enum logic [4:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_PUT, S_START,
    S_VN_RD, S_VN_A, S_CLR, S_ITEM, S_ITEM_RD, S_ITEM_V,
    S_DP_RD, S_DP_WR, S_CHK_RD, S_CHK_ACC, S_DECIDE
  } state_t;

  typedef enum logic [1:0] {PH_LAST, PH_FIRST, PH_BISECT} phase_t;

  state_t              state_r;
  phase_t              phase_r;
  logic [TW-1:0]       target_r;
  logic [TW-1:0]       val_r;
  logic                last_r;
  logic [IW-1:0]       count_r;
  logic [XW-1:0]       pos_r;
  logic [TW-1:0]       k_r;
  logic [XW-1:0]       ind_r, low_r, high_r;
  logic [TW-1:0]       a_r, dv_r, j_r;
  logic [IW-1:0]       ii_r;
  logic                hit_r;
  logic                out_valid_r;
  logic [CW-1:0]       out_cnt_r;

  // sorted value store
  logic [TW-1:0]       store_mem [MAX_ITEMS];
  logic [XW-1:0]       store_raddr_r;
  logic [TW-1:0]       store_q;
  logic                store_we;
  logic [XW-1:0]       store_waddr;
  logic [TW-1:0]       store_wdata;

  // reachability bits 0..K-1 (bit K never feeds a check)
  logic                reach_mem [MAX_TARGET];
  logic [RW-1:0]       ra_r, rb_r;
  logic                ra_q, rb_q;
  logic                reach_we;
  logic [RW-1:0]       reach_waddr;
  logic                reach_wdata;

  logic [TW-1:0]       in_val_cap;
  logic [TW-1:0]       k_eff;
  logic [TW-1:0]       item_v;
  logic [XW:0]         mid_sum;
  logic [XW-1:0]       mid;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = ssuc_pkg::OUT_TDATA_W'(out_cnt_r);

  // cap incoming value at MAX_TARGET
  assign in_val_cap = (32'(in_tdata[ssuc_pkg::VALUE_W-1:0]) > MAX_TARGET) ?
                      TW'(MAX_TARGET) : TW'(in_tdata[ssuc_pkg::VALUE_W-1:0]);
  assign k_eff      = (32'(target_r) > MAX_TARGET) ? TW'(MAX_TARGET) : target_r;
  assign item_v     = (store_q > k_r) ? k_r : store_q;
  assign mid_sum    = {1'b0, low_r} + {1'b0, high_r};
  assign mid        = mid_sum[XW:1];

  // store and reach write ports
  always_comb begin
    store_we    = 1'b0;
    store_waddr = pos_r;
    store_wdata = val_r;
    reach_we    = 1'b0;
    reach_waddr = j_r[RW-1:0];
    reach_wdata = 1'b0;
    unique case (state_r)
      S_INS_CMP: begin
        if (store_q > val_r) begin
          store_we    = 1'b1;
          store_wdata = store_q;
        end
      end
      S_INS_PUT: store_we = 1'b1;
      S_CLR: begin
        reach_we    = 1'b1;
        reach_wdata = (j_r == '0);
      end
      S_DP_WR: begin
        reach_we    = 1'b1;
        reach_wdata = ra_q | rb_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
    store_q <= store_mem[store_raddr_r];
    if (reach_we) begin
      reach_mem[reach_waddr] <= reach_wdata;
    end
    ra_q <= reach_mem[ra_r];
    rb_q <= reach_mem[rb_r];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_LAST;
      target_r    <= TW'(1);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        target_r <= TW'(cfg_data);
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            val_r  <= in_val_cap;
            last_r <= in_tlast;
            if (32'(count_r) < MAX_ITEMS) begin
              pos_r <= count_r[XW-1:0];
              if (count_r != '0) begin
                store_raddr_r <= XW'(count_r - IW'(1));
                state_r       <= S_INS_RD;
              end else begin
                state_r <= S_INS_PUT;
              end
            end else if (in_tlast) begin
              state_r <= S_START;
            end
          end
        end
        S_INS_RD: state_r <= S_INS_CMP;
        S_INS_CMP: begin
          // shift the larger entry up one place and step down
          if (store_q > val_r) begin
            pos_r <= pos_r - XW'(1);
            if (pos_r != XW'(1)) begin
              store_raddr_r <= pos_r - XW'(2);
              state_r       <= S_INS_RD;
            end else begin
              state_r <= S_INS_PUT;
            end
          end else begin
            state_r <= S_INS_PUT;
          end
        end
        S_INS_PUT: begin
          count_r <= count_r + IW'(1);
          state_r <= last_r ? S_START : S_IDLE;
        end
        S_START: begin
          // hold until the previous result has left
          if (!out_valid_r) begin
            k_r <= k_eff;
            if (count_r == '0) begin
              out_cnt_r   <= '0;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              phase_r       <= PH_LAST;
              ind_r         <= XW'(count_r - IW'(1));
              store_raddr_r <= XW'(count_r - IW'(1));
              state_r       <= S_VN_RD;
            end
          end
        end
        S_VN_RD: state_r <= S_VN_A;
        S_VN_A: begin
          a_r <= item_v;
          if (item_v >= k_r) begin
            hit_r   <= 1'b1;
            state_r <= S_DECIDE;
          end else if (item_v == '0) begin
            hit_r   <= 1'b0;
            state_r <= S_DECIDE;
          end else begin
            j_r     <= '0;
            state_r <= S_CLR;
          end
        end
        S_CLR: begin
          if (j_r == k_r - TW'(1)) begin
            ii_r    <= '0;
            state_r <= S_ITEM;
          end else begin
            j_r <= j_r + TW'(1);
          end
        end
        S_ITEM: begin
          if (ii_r == count_r) begin
            j_r     <= k_r - a_r;
            ra_r    <= RW'(k_r - a_r);
            hit_r   <= 1'b0;
            state_r <= S_CHK_RD;
          end else if (ii_r[XW-1:0] == ind_r) begin
            ii_r <= ii_r + IW'(1);
          end else begin
            store_raddr_r <= ii_r[XW-1:0];
            state_r       <= S_ITEM_RD;
          end
        end
        S_ITEM_RD: state_r <= S_ITEM_V;
        S_ITEM_V: begin
          // values of zero or at least K leave bits below K unchanged
          if (item_v == '0 || item_v >= k_r) begin
            ii_r    <= ii_r + IW'(1);
            state_r <= S_ITEM;
          end else begin
            dv_r    <= item_v;
            j_r     <= k_r - TW'(1);
            ra_r    <= RW'(k_r - TW'(1));
            rb_r    <= RW'(k_r - TW'(1) - item_v);
            state_r <= S_DP_RD;
          end
        end
        S_DP_RD: state_r <= S_DP_WR;
        S_DP_WR: begin
          if (j_r == dv_r) begin
            ii_r    <= ii_r + IW'(1);
            state_r <= S_ITEM;
          end else begin
            j_r     <= j_r - TW'(1);
            ra_r    <= RW'(j_r - TW'(1));
            rb_r    <= RW'(j_r - TW'(1) - dv_r);
            state_r <= S_DP_RD;
          end
        end
        S_CHK_RD: state_r <= S_CHK_ACC;
        S_CHK_ACC: begin
          hit_r <= hit_r | ra_q;
          if (j_r == k_r - TW'(1)) begin
            state_r <= S_DECIDE;
          end else begin
            j_r     <= j_r + TW'(1);
            ra_r    <= RW'(j_r + TW'(1));
            state_r <= S_CHK_RD;
          end
        end
        S_DECIDE: begin
          state_r <= S_VN_RD;
          unique case (phase_r)
            PH_LAST: begin
              if (!hit_r) begin
                out_cnt_r   <= CW'(count_r);
                out_valid_r <= 1'b1;
                count_r     <= '0;
                state_r     <= S_IDLE;
              end else begin
                phase_r       <= PH_FIRST;
                ind_r         <= '0;
                store_raddr_r <= '0;
              end
            end
            PH_FIRST: begin
              if (hit_r || count_r <= IW'(2)) begin
                out_cnt_r   <= hit_r ? '0 : CW'(count_r - IW'(1));
                out_valid_r <= 1'b1;
                count_r     <= '0;
                state_r     <= S_IDLE;
              end else begin
                low_r         <= '0;
                high_r        <= XW'(count_r - IW'(1));
                phase_r       <= PH_BISECT;
                ind_r         <= XW'((count_r - IW'(1)) >> 1);
                store_raddr_r <= XW'((count_r - IW'(1)) >> 1);
              end
            end
            PH_BISECT: begin
              logic [XW-1:0] nlow, nhigh;
              logic [XW:0]   nsum;
              nlow  = hit_r ? low_r : ind_r;
              nhigh = hit_r ? ind_r : high_r;
              nsum  = {1'b0, nlow} + {1'b0, nhigh};
              low_r  <= nlow;
              high_r <= nhigh;
              if ({1'b0, nlow} + (XW+1)'(1) < {1'b0, nhigh}) begin
                ind_r         <= nsum[XW:1];
                store_raddr_r <= nsum[XW:1];
              end else begin
                out_cnt_r   <= CW'(nhigh);
                out_valid_r <= 1'b1;
                count_r     <= '0;
                state_r     <= S_IDLE;
              end
            end
            default: state_r <= S_IDLE;
          endcase
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // bisection midpoint of the current bounds, kept for the checks below
  logic mid_in_range;
  assign mid_in_range = (mid >= low_r) && (mid <= high_r);

  `SSUC_ALWAYS(a_count_bound, 32'(count_r) <= MAX_ITEMS)
  `SSUC_ALWAYS(a_out_bound, !out_valid_r || 32'(out_cnt_r) <= MAX_ITEMS)
  `SSUC_ALWAYS(a_reach_wr_bound, !reach_we || 32'(reach_waddr) < 32'(k_r))
  `SSUC_ASSERT(a_bisect_order, (state_r == S_DECIDE && phase_r == PH_BISECT) |->
    (low_r < ind_r && ind_r < high_r && mid_in_range))

endmodule

### tb/sv/tb_subset_sum_unneeded_item_count_core.sv
// ---------------------------------------------------------------------------
// tb_subset_sum_unneeded_item_count_core
// Streams value sets into the subset-sum unneeded-count core under several
// target settings and random handshake gaps. Each result is checked against
// a behavioral prediction of the sorted store and the reachability search.
// ---------------------------------------------------------------------------
module tb_subset_sum_unneeded_item_count_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 4096;
  localparam int TARGET_CAP  = 4096;
  localparam int STALL_LIMIT = 500000;  // cycles with no transaction at all
  localparam int DRAIN_WAIT  = 64;

  // -------------------------------------------------------------------------
  // Scoreboard: mirrors the value store and target, predicts each count.
  // -------------------------------------------------------------------------
  class count_scoreboard;
    int unsigned target;
    int unsigned held[$];
    int unsigned expected_counts[$];
    int          errors;

    function new();
      target = 1;
      errors = 0;
    endfunction

    // Is the value at sorted position idx part of some minimal good subset?
    function bit value_is_needed(int idx, int unsigned k);
      bit          reach [0:TARGET_CAP];
      int unsigned a, v, dst;
      a = (held[idx] > k) ? k : held[idx];
      if (a >= k) return 1;
      for (int j = 0; j <= TARGET_CAP; j++) reach[j] = 0;
      reach[0] = 1;
      for (int i = 0; i < held.size(); i++) begin
        if (i == idx) continue;
        v = (held[i] > k) ? k : held[i];
        // walk downward so a value is folded in only once; sums saturate at k
        for (int j = k; j >= 0; j--) begin
          if (reach[j]) begin
            dst = j + v;
            if (dst > k) dst = k;
            reach[dst] = 1;
          end
        end
      end
      for (int unsigned j = k - a; j < k; j++)
        if (reach[j]) return 1;
      return 0;
    endfunction

    function int unsigned unneeded_count();
      int unsigned k, n, lo, hi, mid;
      k = (target > TARGET_CAP) ? TARGET_CAP : target;
      n = held.size();
      if (n == 0) return 0;
      if (!value_is_needed(n - 1, k)) return n;
      if (value_is_needed(0, k)) return 0;
      lo = 0;
      hi = n - 1;
      while (lo + 1 < hi) begin
        mid = (lo + hi) / 2;
        if (value_is_needed(mid, k)) hi = mid;
        else lo = mid;
      end
      return hi;
    endfunction

    function void note_item(int unsigned value, bit last);
      int unsigned v;
      v = (value > TARGET_CAP) ? TARGET_CAP : value;
      if (held.size() < STORE_DEPTH) begin
        held.push_back(v);
        held.sort();
      end
      if (last) begin
        expected_counts.push_back(unneeded_count());
        held.delete();
      end
    endfunction

    function void check_result(int unsigned count);
      int unsigned want;
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $realtime, count);
        errors++;
        return;
      end
      want = expected_counts.pop_front();
      if (count != want) begin
        $display("%0t: unneeded_count mismatch, expected %0d, actual %0d",
                 $realtime, want, count);
        errors++;
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [ssuc_pkg::TARGET_W-1:0]    cfg_data;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [ssuc_pkg::IN_TDATA_W-1:0]  in_tdata;   // item_value[19:0], zero fill [23:20]
  logic                             in_tlast;   // last_item
  logic                             out_tvalid;
  logic                             out_tready;
  logic [ssuc_pkg::OUT_TDATA_W-1:0] out_tdata;  // unneeded_count[12:0], zero fill [15:13]

  count_scoreboard sb;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_request;   // set by the stimulus, served by the receiver
  bit          hold_served;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  subset_sum_unneeded_item_count_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // -------------------------------------------------------------------------
  // Monitors: sample handshakes at the edge, before any update lands.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.target = 32'(cfg_data);
      if (in_tvalid && in_tready)
        sb.note_item(32'(in_tdata[ssuc_pkg::VALUE_W-1:0]), in_tlast);
      if (out_tvalid && out_tready)
        sb.check_result(32'(out_tdata[ssuc_pkg::COUNT_W-1:0]));
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (in_tvalid && in_tready) ||
        (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random back-pressure, plus one long hold on request so the
  // core fills up and must stall its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_request && !hold_served) begin
      out_tready  <= 1'b0;
      hold_left   <= 3000;
      hold_served <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one value; return right after the edge that took it.
  task automatic send_item(input int unsigned value, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ssuc_pkg::IN_TDATA_W'(value[ssuc_pkg::VALUE_W-1:0]);
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold the input quiet until every result is back, then let a late
  // result-free tail settle before touching the register.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_counts.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_target(input int unsigned value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value[ssuc_pkg::TARGET_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_set(input int unsigned values[$]);
    foreach (values[i]) send_item(values[i], i == values.size() - 1);
  endtask

  // Random value for a set under target k: mostly near the target,
  // occasionally zero or a raw wide value that gets capped.
  function automatic int unsigned pick_value(int unsigned k);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) return 0;
    if (roll < 10) return $urandom_range(20'hFFFFF);
    return $urandom_range(1, k + k / 2 + 1);
  endfunction

  task automatic random_sets(input int unsigned item_budget);
    int unsigned sent, n, k;
    int unsigned vals[$];
    sent = 0;
    while (sent < item_budget) begin
      if ($urandom_range(9) == 0) begin
        // change the target between sets; sometimes a wider one with few values
        if ($urandom_range(3) == 0) k = $urandom_range(100, 300);
        else k = $urandom_range(1, 48);
        write_target(k);
      end
      k = (sb.target > TARGET_CAP) ? TARGET_CAP : sb.target;
      n = (k > 64) ? $urandom_range(1, 4) :
          ($urandom_range(7) == 0) ? $urandom_range(11, 18) : $urandom_range(1, 10);
      vals.delete();
      repeat (n) vals.push_back(pick_value(k));
      send_set(vals);
      sent += n;
    end
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 63;
    hold_request  = 1'b0;
    hold_served   = 1'b0;
    hold_left     = 0;
    quiet_cycles  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset target of one: every positive value is needed.
    send_set('{3, 0, 1});
    // Target zero: the result is zero whatever the values.
    write_target(0);
    send_set('{0, 5});
    // Register all ones: target clamps to the target cap; wide values cap.
    write_target(8191);
    send_set('{20'hFFFFF, 1});
    write_target(4097);
    send_set('{4096, 4095, 4097});
    write_target(4096);
    send_set('{1});
    // Classic mix: small values alongside large ones, all of them needed.
    write_target(10);
    send_set('{1, 2, 4, 9, 3, 20'h80000});
    send_set('{1, 1, 1});               // nothing reaches: all unneeded
    send_set('{5, 5, 2, 0});

    random_sets(180);

    // Second phase: sender idles more, receiver less.
    wait_drained();
    send_idle_pct = 63;
    recv_idle_pct = 10;
    random_sets(180);

    // Third phase: no idling, with one long receiver hold up front.
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_target(12);
    hold_request = 1'b1;
    random_sets(170);

    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_counts.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.expected_counts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ssuc_pkg.sv
hw/rtl/subset_sum_unneeded_item_count_core.sv
tb/sv/tb_subset_sum_unneeded_item_count_core.sv
